>>> src/bsm_pkg.sv
// Shared types and constants of the bounded stack machine.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int VALUE_W         = 20;
  localparam int DEPTH_OUT_W     = 7;

  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0,
    REQ_POP  = 3'd1,
    REQ_DUP  = 3'd2,
    REQ_ADD  = 3'd3,
    REQ_SUB  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_OVER  = 3'd2,
    ST_UNDER = 3'd3,
    ST_FULL  = 3'd4,
    ST_SKIP  = 3'd5
  } status_t;

endpackage

>>> src/bsm_if.sv
// Valid/ready channel interfaces for instructions and results.
`timescale 1ns / 1ps

interface bsm_in_if
  import bsm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] push_value;
  logic               end_of_program;

  modport source (output valid, req_type, push_value, end_of_program, input ready);
  modport sink   (input valid, req_type, push_value, end_of_program, output ready);
endinterface

interface bsm_out_if
  import bsm_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [VALUE_W-1:0]     top_value;
  logic [DEPTH_OUT_W-1:0] stack_depth;
  logic                   program_done;
  logic                   final_valid;
  logic [VALUE_W-1:0]     final_value;

  modport source (output valid, status, top_value, stack_depth, program_done,
                  final_valid, final_value, input ready);
  modport sink   (input valid, status, top_value, stack_depth, program_done,
                  final_valid, final_value, output ready);
endinterface

>>> src/bounded_stack_machine.sv
// Top level of the bounded stack machine: stack memory, top register, result register.
//
// in_ch carries one stack instruction per transfer (push, pop, duplicate, add,
// subtract) with an end_of_program marker. out_ch returns exactly one result
// per instruction: status, top of stack, depth and, at program end, the final
// value with its valid flag.
// The top of stack lives in a register; the entries below it live in a
// synchronous memory with one read and one write port and a registered
// read. The entry just under the top is kept read out in a data register.
// The result appears in the output register in the cycle after the
// instruction transfer. After each transfer in_ch.ready drops while the
// entry under the new top is re-read from the memory, so the next
// instruction waits for that re-read.
// Reset clears the depth, the sticky error flag and the output valid; the
// memory is not cleared, since only entries below the depth are ever used.
// When the receiver stalls, the result holds in the output register and
// in_ch.ready stays low until that result is taken or taken in the same cycle.
`timescale 1ns / 1ps

module bounded_stack_machine
  import bsm_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  bsm_in_if.sink    in_ch,
  bsm_out_if.source out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  logic [VALUE_W-1:0] mem [STACK_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [VALUE_W-1:0] top_r;
  logic [CW-1:0]      count_r;
  logic               error_r;
  logic               busy_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [VALUE_W-1:0]     out_top_r;
  logic [DEPTH_OUT_W-1:0] out_depth_r;
  logic                   out_done_r;
  logic                   out_fvalid_r;
  logic [VALUE_W-1:0]     out_fvalue_r;

  logic               accept;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W:0]   diff;
  status_t            status_c;
  logic [VALUE_W-1:0] top_nxt;
  logic [CW-1:0]      count_nxt;
  logic               error_nxt;
  logic               we_c;
  logic               fvalid_c;
  logic [VALUE_W-1:0] fvalue_c;
  logic [VALUE_W-1:0] top_out_c;

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_m1      = count_r - CNT_ONE;
  assign cnt_m2      = count_r - CNT_TWO;
  assign sum         = {1'b0, top_r} + {1'b0, rd_data_r};
  assign diff        = {1'b0, top_r} - {1'b0, rd_data_r};

  always_comb begin
    status_c  = ST_OK;
    top_nxt   = top_r;
    count_nxt = count_r;
    error_nxt = error_r;
    we_c      = 1'b0;
    fvalid_c  = 1'b0;
    fvalue_c  = '0;
    if (error_r) begin
      status_c = ST_SKIP;
    end else begin
      case (req_t'(in_ch.req_type))
        REQ_PUSH: begin
          if (in_ch.push_value[31]) begin
            status_c = ST_UNDER;
          end else if (in_ch.push_value[30:VALUE_W] != '0) begin
            status_c = ST_OVER;
          end else if (count_r >= CNT_FULL) begin
            status_c = ST_FULL;
          end else begin
            we_c      = (count_r != '0);
            top_nxt   = in_ch.push_value[VALUE_W-1:0];
            count_nxt = count_r + CNT_ONE;
          end
        end
        REQ_POP: begin
          if (count_r == '0) begin
            status_c = ST_FEW;
          end else begin
            top_nxt   = rd_data_r;
            count_nxt = cnt_m1;
          end
        end
        REQ_DUP: begin
          if (count_r == '0) begin
            status_c = ST_FEW;
          end else if (count_r >= CNT_FULL) begin
            status_c = ST_FULL;
          end else begin
            we_c      = 1'b1;
            count_nxt = count_r + CNT_ONE;
          end
        end
        REQ_ADD: begin
          if (count_r < CNT_TWO) begin
            status_c = ST_FEW;
          end else if (sum[VALUE_W]) begin
            status_c = ST_OVER;
          end else begin
            top_nxt   = sum[VALUE_W-1:0];
            count_nxt = cnt_m1;
          end
        end
        REQ_SUB: begin
          if (count_r < CNT_TWO) begin
            status_c = ST_FEW;
          end else if (diff[VALUE_W]) begin
            status_c = ST_UNDER;
          end else begin
            top_nxt   = diff[VALUE_W-1:0];
            count_nxt = cnt_m1;
          end
        end
        default: status_c = ST_OK;
      endcase
      if (status_c != ST_OK) begin
        error_nxt = 1'b1;
        top_nxt   = top_r;
        count_nxt = count_r;
        we_c      = 1'b0;
      end
    end
    if (in_ch.end_of_program) begin
      fvalid_c  = !error_nxt && (count_nxt != '0);
      fvalue_c  = fvalid_c ? top_nxt : '0;
      count_nxt = '0;
      error_nxt = 1'b0;
    end
    top_out_c = (count_nxt != '0) ? top_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (accept && we_c) begin
      mem[cnt_m1[AW-1:0]] <= top_r;
    end
    rd_data_r <= mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      error_r     <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= accept;
      if (accept) begin
        count_r     <= count_nxt;
        error_r     <= error_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r        <= top_nxt;
      out_status_r <= status_c;
      out_top_r    <= top_out_c;
      out_depth_r  <= DEPTH_OUT_W'(count_nxt);
      out_done_r   <= in_ch.end_of_program;
      out_fvalid_r <= fvalid_c;
      out_fvalue_r <= fvalue_c;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.top_value    = out_top_r;
  assign out_ch.stack_depth  = out_depth_r;
  assign out_ch.program_done = out_done_r;
  assign out_ch.final_valid  = out_fvalid_r;
  assign out_ch.final_value  = out_fvalue_r;

  a_refill_stall: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("instruction taken during refill cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("no result after instruction transfer");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("stack depth beyond capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_program |=> count_r == '0 && !error_r)
    else $error("program end left stack or error flag set");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.program_done |-> out_ch.stack_depth == '0 &&
      out_ch.top_value == '0)
    else $error("program end result reports a non-empty stack");

endmodule
